FILE: rtl/mdf_pkg.sv
// Shared types, codes and sizes of the multidrop UART transaction framer.
`timescale 1ns / 1ps
package mdf_pkg;

   // Payload limits and frame constants
   localparam int unsigned MAX_PAYLOAD = 30;
   localparam logic [4:0]  MAX_PAYLOAD_LEN = 5'(MAX_PAYLOAD);
   localparam logic [7:0]  SUM_SEED = 8'hAA;
   localparam logic [15:0] COUNT_FULL = 16'hFFFF;

   // Result queue sizing
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Input opcodes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_TX     = 2'd1;
   localparam logic [1:0] OP_RX     = 2'd2;
   localparam logic [1:0] OP_RX_ERR = 2'd3;

   // Result kinds
   localparam logic [2:0] KIND_TX_WORD   = 3'd0;
   localparam logic [2:0] KIND_RX_BYTE   = 3'd1;
   localparam logic [2:0] KIND_GOOD      = 3'd2;
   localparam logic [2:0] KIND_BAD_SUM   = 3'd3;
   localparam logic [2:0] KIND_FRAME_ERR = 3'd4;

   // Control register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_TIME       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURNAROUND_TIME = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CALLBACK_TIME   = 2'd2;

   // Control register reset values
   localparam logic [15:0] BYTE_TIME_RESET       = 16'd35;
   localparam logic [15:0] TURNAROUND_TIME_RESET = 16'd20;
   localparam logic [15:0] CALLBACK_TIME_RESET   = 16'd10;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] device_id;
      logic [4:0] tx_count;
      logic [4:0] rx_count;
      logic [1:0] callback_count;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [8:0]  word;
      logic        last;
      logic [21:0] slot_time;
      logic [15:0] checksum_error_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] byte_time;
      logic [15:0] turnaround_time;
      logic [15:0] callback_time;
   } cfg_type;

   // Up to two result words produced by one item; second only with first
   typedef struct packed {
      logic    valid0;
      logic    valid1;
      rsp_type rsp0;
      rsp_type rsp1;
   } push_type;

endpackage

FILE: rtl/mdf_in_stage.sv
// Input register of the framer: holds one accepted request word.
`timescale 1ns / 1ps
module mdf_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mdf_pkg::req_type req_data,
   input  logic             room,
   output logic             proc_valid,
   output mdf_pkg::req_type proc_item
);
   import mdf_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;
   logic    load;

   // Hold the word until the result queue has room for two results
   assign proc_valid = valid_ff && room;
   assign req_stall  = valid_ff && !room;
   assign load       = req_valid && !req_stall;
   assign proc_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_data;
      end else if (proc_valid) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

FILE: rtl/mdf_core.sv
// Transaction state and per-word framing, checksum and slot time logic.
`timescale 1ns / 1ps
module mdf_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              proc_valid,
   input  mdf_pkg::req_type  proc_item,
   input  mdf_pkg::cfg_type  cfg,
   output mdf_pkg::push_type push
);
   import mdf_pkg::*;

   logic [7:0]  id_ff, id_in;
   logic [4:0]  tx_len_ff, tx_len_in;
   logic [4:0]  rx_len_ff, rx_len_in;
   logic [4:0]  tx_pos_ff, tx_pos_in;
   logic [4:0]  rx_pos_ff, rx_pos_in;
   logic [7:0]  tx_sum_ff, tx_sum_in;
   logic [7:0]  rx_sum_ff, rx_sum_in;
   logic        rx_active_ff, rx_active_in;
   logic [15:0] bad_ff, bad_in;

   logic [4:0]  txc_sat, rxc_sat, len_max, tx_pos_inc;
   logic [5:0]  slot_bytes;
   logic [21:0] byte_part;
   logic [17:0] cb_part;
   logic [21:0] slot;
   logic [7:0]  tx_sum_new, rx_sum_new;

   // Clamp counts and work out the slot length of a start word
   always_comb begin
      txc_sat = (proc_item.tx_count > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : proc_item.tx_count;
      rxc_sat = (proc_item.rx_count > MAX_PAYLOAD_LEN) ? MAX_PAYLOAD_LEN : proc_item.rx_count;
      len_max = (txc_sat > rxc_sat) ? txc_sat : rxc_sat;
      slot_bytes = (len_max != 5'd0) ? ({1'b0, len_max} + 6'd2) : 6'd1;
      byte_part = {16'd0, slot_bytes} * {6'd0, cfg.byte_time};
      cb_part   = {16'd0, proc_item.callback_count} * {2'd0, cfg.callback_time};
      slot      = byte_part + {6'd0, cfg.turnaround_time} + {4'd0, cb_part};
   end

   assign tx_sum_new = tx_sum_ff ^ proc_item.data_byte;
   assign rx_sum_new = rx_sum_ff ^ proc_item.data_byte;
   assign tx_pos_inc = tx_pos_ff + 5'd1;

   // Advance transaction state and build the results of one word
   always_comb begin
      id_in        = id_ff;
      tx_len_in    = tx_len_ff;
      rx_len_in    = rx_len_ff;
      tx_pos_in    = tx_pos_ff;
      rx_pos_in    = rx_pos_ff;
      tx_sum_in    = tx_sum_ff;
      rx_sum_in    = rx_sum_ff;
      rx_active_in = rx_active_ff;
      bad_in       = bad_ff;
      push         = '0;

      unique case (proc_item.opcode)
         OP_START: begin
            id_in        = proc_item.device_id;
            tx_len_in    = txc_sat;
            rx_len_in    = rxc_sat;
            tx_pos_in    = 5'd0;
            rx_pos_in    = 5'd0;
            tx_sum_in    = SUM_SEED ^ proc_item.device_id;
            rx_sum_in    = proc_item.device_id;
            rx_active_in = 1'b1;
            push.valid0           = 1'b1;
            push.rsp0.result_kind = KIND_TX_WORD;
            push.rsp0.word        = {1'b1, proc_item.device_id};
            push.rsp0.last        = (txc_sat == 5'd0);
            push.rsp0.slot_time   = slot;
         end
         OP_TX: begin
            if (tx_pos_ff < tx_len_ff) begin
               tx_sum_in = tx_sum_new;
               tx_pos_in = tx_pos_inc;
               push.valid0           = 1'b1;
               push.rsp0.result_kind = KIND_TX_WORD;
               push.rsp0.word        = {1'b0, proc_item.data_byte};
               // Close the frame with the checksum word
               if (tx_pos_inc == tx_len_ff) begin
                  push.valid1           = 1'b1;
                  push.rsp1.result_kind = KIND_TX_WORD;
                  push.rsp1.word        = {1'b0, tx_sum_new};
                  push.rsp1.last        = 1'b1;
               end
            end
         end
         OP_RX: begin
            if (rx_active_ff) begin
               rx_sum_in = rx_sum_new;
               push.valid0    = 1'b1;
               push.rsp0.word = {1'b0, proc_item.data_byte};
               if (rx_pos_ff < rx_len_ff) begin
                  rx_pos_in             = rx_pos_ff + 5'd1;
                  push.rsp0.result_kind = KIND_RX_BYTE;
               end else begin
                  // Checksum byte: give the verdict and go idle
                  rx_active_in = 1'b0;
                  if (rx_sum_new == SUM_SEED) begin
                     push.rsp0.result_kind = KIND_GOOD;
                  end else begin
                     push.rsp0.result_kind = KIND_BAD_SUM;
                     if (bad_ff != COUNT_FULL) begin
                        bad_in = bad_ff + 16'd1;
                     end
                  end
               end
            end
         end
         OP_RX_ERR: begin
            rx_active_in          = 1'b0;
            push.valid0           = 1'b1;
            push.rsp0.result_kind = KIND_FRAME_ERR;
         end
         default: begin
         end
      endcase

      push.rsp0.checksum_error_count = bad_in;
      push.rsp1.checksum_error_count = bad_in;
      if (!proc_valid) begin
         push.valid0 = 1'b0;
         push.valid1 = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff        <= '0;
         tx_len_ff    <= '0;
         rx_len_ff    <= '0;
         tx_pos_ff    <= '0;
         rx_pos_ff    <= '0;
         tx_sum_ff    <= '0;
         rx_sum_ff    <= '0;
         rx_active_ff <= 1'b0;
         bad_ff       <= '0;
      end else if (proc_valid) begin
         id_ff        <= id_in;
         tx_len_ff    <= tx_len_in;
         rx_len_ff    <= rx_len_in;
         tx_pos_ff    <= tx_pos_in;
         rx_pos_ff    <= rx_pos_in;
         tx_sum_ff    <= tx_sum_in;
         rx_sum_ff    <= rx_sum_in;
         rx_active_ff <= rx_active_in;
         bad_ff       <= bad_in;
      end
   end

   // Error counter only climbs between resets
   a_bad_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> bad_ff >= $past(bad_ff))
      else $error("checksum error count decreased");

   // A second result is only ever the closing checksum word
   a_second_is_sum: assert property (@(posedge clock) disable iff (reset)
      push.valid1 |-> push.valid0 && push.rsp1.last && proc_item.opcode == OP_TX)
      else $error("unexpected second result");

   // Transmit position never runs past the frame length
   a_tx_pos_bound: assert property (@(posedge clock) disable iff (reset)
      tx_pos_ff <= tx_len_ff)
      else $error("transmit position beyond length");

endmodule

FILE: rtl/mdf_rsp_queue.sv
// Result queue: takes up to two result words a cycle, hands out one unless stalled.
`timescale 1ns / 1ps
module mdf_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  mdf_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mdf_pkg::rsp_type  rsp_data
);
   import mdf_pkg::*;

   rsp_type              entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_PTR_W-1:0] wr_ptr_next;
   logic                 pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign room        = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.valid1) begin
         wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(2);
      end else if (push.valid0) begin
         wr_ptr_in = wr_ptr_next;
      end
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push.valid0) + RSP_CNT_W'(push.valid1)
                  - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store result words
   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entry_ff[wr_ptr_ff] <= push.rsp0;
      end
      if (push.valid1) begin
         entry_ff[wr_ptr_next] <= push.rsp1;
      end
   end

   // Never push without room for two words
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid0 |-> count_ff <= RSP_CNT_W'(RSP_DEPTH - 2))
      else $error("result queue overflow");

   // A lone pop drops occupancy by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      pop && !push.valid0 |=> count_ff == $past(count_ff) - RSP_CNT_W'(1))
      else $error("result queue count slip");

endmodule

FILE: rtl/multidrop_uart_transaction_framer.sv
// Top level of the 9-bit multidrop UART transaction framer (master side).
// Path: a request word accepted into the input register passes on to the result
//   queue before its first result word shows on rsp_.
// Throughput: one request word per cycle while the result queue has room;
//   a frame-ending transmit word yields two results, sent one at a time.
// Reset: synchronous, active high; clears transaction state, the error
//   counter and the queues, and loads the timing registers with 35, 20, 10.
`timescale 1ns / 1ps
module multidrop_uart_transaction_framer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mdf_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mdf_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [mdf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [15:0]                         csr_wdata
);
   import mdf_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   req_type  proc_item;
   logic     proc_valid;
   logic     room;
   push_type push;

   // Write timing registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BYTE_TIME:       cfg_in.byte_time       = csr_wdata;
            CSR_TURNAROUND_TIME: cfg_in.turnaround_time = csr_wdata;
            CSR_CALLBACK_TIME:   cfg_in.callback_time   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.byte_time       <= BYTE_TIME_RESET;
         cfg_ff.turnaround_time <= TURNAROUND_TIME_RESET;
         cfg_ff.callback_time   <= CALLBACK_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mdf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .room       (room),
      .proc_valid (proc_valid),
      .proc_item  (proc_item)
   );

   mdf_core u_core (
      .clock      (clock),
      .reset      (reset),
      .proc_valid (proc_valid),
      .proc_item  (proc_item),
      .cfg        (cfg_ff),
      .push       (push)
   );

   mdf_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Stall only while a word is held back for lack of room in the result queue
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !room && !proc_valid)
      else $error("request stalled without cause");

endmodule
